FILE: design/bb3_pkg.sv
package bb3_pkg;

  // Default line store depth (largest frame width supported).
  localparam int unsigned MAX_WIDTH_DEF = 1024;

  // Field widths.
  localparam int unsigned CH_W  = 8;
  localparam int unsigned PIX_W = 3 * CH_W;
  localparam int unsigned FW_W  = 11;
  localparam int unsigned FH_W  = 16;
  localparam int unsigned CFG_W = 16;

  // Neighbor count and rounding arithmetic.
  // The rounded mean is floor((2*sum + count) / (2*count)), done as a
  // multiply by a rounded-up reciprocal of 2*count scaled by 2^RECIP_SHIFT.
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned SUM_W       = 12;
  localparam int unsigned NUM_W       = 13;
  localparam int unsigned RECIP_W     = 20;
  localparam int unsigned RECIP_SHIFT = 20;

  // Register reset values.
  localparam logic [FW_W-1:0] WIDTH_RESET  = 11'd1024;
  localparam logic [FH_W-1:0] HEIGHT_RESET = 16'd480;

  // Configuration register indexes.
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Item kinds carried on the input tuser.
  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_MUL,
    ST_EMIT
  } state_t;

  // Neighborhood selection shared by all color lanes.
  // Bit 0 of col_en is the left column, bit 0 of row_en the top row.
  typedef struct packed {
    logic [2:0]         col_en;
    logic [2:0]         row_en;
    logic [CNT_W-1:0]   count;
    logic [RECIP_W-1:0] recip;
  } lane_ctl_t;

  // Number of in-frame neighbors from the column and row enables.
  function automatic logic [CNT_W-1:0] count_of(logic [2:0] col_en, logic [2:0] row_en);
    logic [1:0] nc;
    logic [1:0] nr;
    nc = 2'(col_en[0]) + 2'(col_en[1]) + 2'(col_en[2]);
    nr = 2'(row_en[0]) + 2'(row_en[1]) + 2'(row_en[2]);
    return CNT_W'(nc) * CNT_W'(nr);
  endfunction

  // ceil(2^RECIP_SHIFT / (2*count)); exact floor for numerators below 2^NUM_W.
  function automatic logic [RECIP_W-1:0] recip_of(logic [CNT_W-1:0] count);
    logic [RECIP_W-1:0] r;
    case (count)
      4'd1:    r = 20'd524288;
      4'd2:    r = 20'd262144;
      4'd3:    r = 20'd174763;
      4'd4:    r = 20'd131072;
      4'd6:    r = 20'd87382;
      4'd9:    r = 20'd58255;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: design/bb3_line_mem.sv
module bb3_line_mem #(
  parameter int unsigned DEPTH  = bb3_pkg::MAX_WIDTH_DEF,
  parameter int unsigned DATA_W = 2 * bb3_pkg::PIX_W
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/bb3_lane.sv
module bb3_lane (
  input  logic                                   clk,
  input  logic [2:0][2:0][bb3_pkg::CH_W-1:0]     win,
  input  bb3_pkg::lane_ctl_t                     ctl,
  output logic [bb3_pkg::CH_W-1:0]               mean
);

  logic [bb3_pkg::SUM_W-1:0]                     sum;
  logic [bb3_pkg::NUM_W-1:0]                     num;
  logic [bb3_pkg::NUM_W-1:0]                     num_q;
  logic [bb3_pkg::RECIP_W-1:0]                   recip_q;
  logic [bb3_pkg::NUM_W+bb3_pkg::RECIP_W-1:0]    prod;

  // Sum of the in-frame neighbors of one color channel.
  always_comb begin
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (ctl.col_en[i] && ctl.row_en[j]) begin
          sum = sum + bb3_pkg::SUM_W'(win[i][j]);
        end
      end
    end
  end

  // Rounding numerator 2*sum + count.
  assign num = {sum, 1'b0} + bb3_pkg::NUM_W'(ctl.count);

  // Stage one: numerator and reciprocal.
  always_ff @(posedge clk) begin
    num_q   <= num;
    recip_q <= ctl.recip;
  end

  assign prod = (bb3_pkg::NUM_W + bb3_pkg::RECIP_W)'(num_q)
              * (bb3_pkg::NUM_W + bb3_pkg::RECIP_W)'(recip_q);

  // Stage two: quotient by reciprocal multiply.
  always_ff @(posedge clk) begin
    mean <= prod[bb3_pkg::RECIP_SHIFT +: bb3_pkg::CH_W];
  end

endmodule

FILE: design/box_blur_3x3_edge_normalized_unit.sv
// 3x3 box blur of an RGB pixel stream with edge-normalized averaging.
// Input beats (s_*) carry pixels in raster order; tuser = 1 marks a drain
// beat. After frame_height rows, one row of frame_width beats (any kind)
// flushes the bottom row. Output beats (m_*) carry the blurred pixel of
// row r-1, column c-1 for input (r,c), plus column width-1 at end of row.
// m_tlast marks the last output of an input beat; m_tuser marks the
// bottom-right pixel of the frame.
// Per input beat: an ignored drain beat is taken in the idle state alone,
// a beat with no output only adds one line store read, and each output
// adds the lane sum stage, the reciprocal multiply stage and the output
// load. Output goes through a register, so a new input beat is taken
// while the last result still waits; a stalled receiver holds the
// sequencer at its output step. Reset clears the counters, the window,
// the result flags and m_tvalid and sets width 1024, height 480; the
// line stores and the output data are not cleared. The user must see to
// it that configuration (cfg_we, cfg_index, cfg_data) is written only
// while idle; the block itself does not enforce it.
module box_blur_3x3_edge_normalized_unit #(
  parameter int unsigned MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [bb3_pkg::PIX_W-1:0]  s_tdata,   // red_in, green_in, blue_in
  input  logic                       s_tuser,   // operation
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [bb3_pkg::PIX_W-1:0]  m_tdata,   // red_out, green_out, blue_out
  output logic                       m_tlast,
  output logic                       m_tuser,   // frame_done
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [bb3_pkg::CFG_W-1:0]  cfg_data
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned CW = (bb3_pkg::FW_W > AW + 1) ? bb3_pkg::FW_W : AW + 1;
  localparam int unsigned PW = bb3_pkg::PIX_W;
  localparam int unsigned CH = bb3_pkg::CH_W;

  bb3_pkg::state_t state, state_next;

  logic [bb3_pkg::FW_W-1:0] frame_width;
  logic [bb3_pkg::FH_W-1:0] frame_height;
  logic [AW-1:0]            column_count;
  logic [bb3_pkg::FH_W-1:0] row_count;

  logic [CW-1:0]            fw_ext;
  logic [AW-1:0]            w_last;
  logic [AW-1:0]            c_cur;
  logic [bb3_pkg::FH_W-1:0] h_eff;
  logic                     drain_cur;
  logic                     stray;
  logic                     take;

  logic [AW-1:0]            c_q;
  logic                     last_q;
  logic                     drain_q;
  logic                     r_ge1_q;
  logic                     r_ge2_q;
  logic [PW-1:0]            pix_q;
  logic                     emit_a;
  logic                     emit_b;

  logic                     mem_we;
  logic [2*PW-1:0]          rd_data;
  logic                     out_free;
  logic                     load_out;

  logic [2:0][2:0][PW-1:0]  window;
  logic [2:0][2:0][PW-1:0]  lane_win;
  bb3_pkg::lane_ctl_t       ctl;
  logic [2:0][CH-1:0]       lane_mean;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bb3_pkg::WIDTH_RESET;
      frame_height <= bb3_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bb3_pkg::REG_WIDTH:  frame_width  <= cfg_data[bb3_pkg::FW_W-1:0];
        bb3_pkg::REG_HEIGHT: frame_height <= cfg_data[bb3_pkg::FH_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective last column and height after clamping.
  assign fw_ext = CW'(frame_width);
  always_comb begin
    if (fw_ext == '0) begin
      w_last = '0;
    end else if (fw_ext > CW'(MAX_WIDTH)) begin
      w_last = AW'(MAX_WIDTH - 1);
    end else begin
      w_last = AW'(fw_ext - CW'(1));
    end
  end

  assign c_cur     = (column_count > w_last) ? w_last : column_count;
  assign h_eff     = (frame_height == '0) ? bb3_pkg::FH_W'(1) : frame_height;
  assign drain_cur = (row_count >= h_eff);
  assign stray     = !drain_cur && (s_tuser == bb3_pkg::OP_DRAIN);
  assign take      = s_tvalid && s_tready && !stray;
  assign out_free  = !m_tvalid || m_tready;

  // Position counters and the latched item.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (take) begin
      if (c_cur == w_last) begin
        column_count <= '0;
        row_count    <= drain_cur ? '0 : row_count + bb3_pkg::FH_W'(1);
      end else begin
        column_count <= c_cur + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      c_q     <= c_cur;
      last_q  <= (c_cur == w_last);
      drain_q <= drain_cur;
      r_ge1_q <= (row_count != '0);
      r_ge2_q <= (row_count > bb3_pkg::FH_W'(1));
      pix_q   <= drain_cur ? '0 : s_tdata;
    end
  end

  // Two line stores in one memory: upper row high, middle row low.
  bb3_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (2 * PW)
  ) u_line_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (c_q),
    .wdata ({rd_data[PW-1:0], pix_q}),
    .re    (take),
    .raddr (c_cur),
    .rdata (rd_data)
  );

  // Window shift and pending result flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
      emit_a <= 1'b0;
      emit_b <= 1'b0;
    end else if (state == bb3_pkg::ST_READ) begin
      window[0] <= window[1];
      window[1] <= window[2];
      window[2] <= {pix_q, rd_data[PW-1:0], rd_data[2*PW-1:PW]};
      emit_a    <= r_ge1_q && (c_q != '0);
      emit_b    <= r_ge1_q && last_q;
    end else if (load_out) begin
      if (emit_a) begin
        emit_a <= 1'b0;
      end else begin
        emit_b <= 1'b0;
      end
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      bb3_pkg::ST_IDLE: begin
        if (take) state_next = bb3_pkg::ST_READ;
      end
      bb3_pkg::ST_READ: begin
        if (r_ge1_q && ((c_q != '0) || last_q)) begin
          state_next = bb3_pkg::ST_CALC;
        end else begin
          state_next = bb3_pkg::ST_IDLE;
        end
      end
      bb3_pkg::ST_CALC: state_next = bb3_pkg::ST_MUL;
      bb3_pkg::ST_MUL:  state_next = bb3_pkg::ST_EMIT;
      bb3_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = (emit_a && emit_b) ? bb3_pkg::ST_CALC : bb3_pkg::ST_IDLE;
        end
      end
      default: state_next = bb3_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_tready = 1'b0;
    mem_we   = 1'b0;
    load_out = 1'b0;
    case (state)
      bb3_pkg::ST_IDLE: s_tready = 1'b1;
      bb3_pkg::ST_READ: mem_we   = 1'b1;
      bb3_pkg::ST_EMIT: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bb3_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Neighborhood of the pixel being blurred: window center for the
  // column-behind result, window right column for the end-of-row result.
  always_comb begin
    if (emit_a) begin
      lane_win   = window;
      ctl.col_en = {1'b1, 1'b1, (c_q > AW'(1))};
    end else begin
      lane_win   = {window[2], window[2], window[1]};
      ctl.col_en = {1'b0, 1'b1, (c_q != '0)};
    end
    ctl.row_en = {!drain_q, 1'b1, r_ge2_q};
    ctl.count  = bb3_pkg::count_of(ctl.col_en, ctl.row_en);
    ctl.recip  = bb3_pkg::recip_of(ctl.count);
  end

  // One lane per color channel.
  for (genvar g = 0; g < 3; g++) begin : g_lane
    logic [2:0][2:0][CH-1:0] ch_win;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          ch_win[i][j] = lane_win[i][j][g*CH +: CH];
        end
      end
    end

    bb3_lane u_lane (
      .clk  (clk),
      .win  (ch_win),
      .ctl  (ctl),
      .mean (lane_mean[g])
    );
  end

  // Merge the lanes into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= lane_mean;
      m_tlast <= !(emit_a && emit_b);
      m_tuser <= !emit_a && drain_q;
    end
  end

  // A new output beat only comes from the output step.
  a_rise_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == bb3_pkg::ST_EMIT)
    else $error("output beat raised outside the output step");

  // The frame end marker is always the last result of its input beat.
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("frame_done without last_of_run");

  // The sum stage only runs with a result pending.
  a_calc_pending: assert property (@(posedge clk) disable iff (rst)
    state == bb3_pkg::ST_CALC |-> emit_a || emit_b)
    else $error("sum stage entered with no result pending");

endmodule
